// ===== sv/ps2_scancode_to_ascii_assert.svh =====
// Assertion macros for the scancode translator.
// No dependencies; the top level includes this file.
`ifndef PS2_SCANCODE_TO_ASCII_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
`define PS2SC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ps2sc: property failed");
`define PS2SC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ps2sc: forbidden condition seen");
`else
`define PS2SC_ASSERT(lbl, clk, rst, prop)
`define PS2SC_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== sv/ps2sc_pkg.sv =====
// Shared types, key codes and character maps of the scancode translator.
// No dependencies.
`default_nettype none
package ps2sc_pkg;

   localparam int CHAR_W    = 7;
   localparam int MAX_CHARS = 4;
   localparam int LEN_W     = 2;

   localparam logic [7:0]        SC_IGNORE  = 8'h7f;
   localparam logic [6:0]        SC_SHIFT_L = 7'h2a;
   localparam logic [6:0]        SC_SHIFT_R = 7'h36;
   localparam logic [6:0]        SC_CAPS   = 7'h3a;
   localparam logic [6:0]        SC_LEFT   = 7'h4b;
   localparam logic [6:0]        SC_RIGHT  = 7'h4d;
   localparam logic [6:0]        SC_UP     = 7'h48;
   localparam logic [6:0]        SC_DOWN   = 7'h50;
   localparam logic [6:0]        SC_HOME   = 7'h47;
   localparam logic [6:0]        SC_END    = 7'h4f;
   localparam logic [6:0]        SC_DEL    = 7'h53;

   localparam logic [CHAR_W-1:0] CH_ESC    = 7'h1b;
   localparam logic [CHAR_W-1:0] CH_CSI    = 7'h5b;
   localparam logic [CHAR_W-1:0] CH_SS3    = 7'h4f;
   localparam logic [CHAR_W-1:0] CH_LEFT   = 7'h44;
   localparam logic [CHAR_W-1:0] CH_RIGHT  = 7'h43;
   localparam logic [CHAR_W-1:0] CH_UP     = 7'h41;
   localparam logic [CHAR_W-1:0] CH_DOWN   = 7'h42;
   localparam logic [CHAR_W-1:0] CH_HOME   = 7'h48;
   localparam logic [CHAR_W-1:0] CH_END    = 7'h46;
   localparam logic [CHAR_W-1:0] CH_DEL    = 7'h33;
   localparam logic [CHAR_W-1:0] CH_TILDE  = 7'h7e;
   localparam logic [CHAR_W-1:0] CH_UNMAP  = 7'h3f;
   localparam logic [CHAR_W-1:0] CH_LC_A   = 7'h61;
   localparam logic [CHAR_W-1:0] CH_LC_Z   = 7'h7a;

   // One queued translation: up to four characters, count minus one.
   typedef struct packed {
      logic [LEN_W-1:0]                   len_m1;
      logic [MAX_CHARS-1:0][CHAR_W-1:0]   chars;
   } entry_type;

   // Front to queue write side.
   typedef struct packed {
      logic      push;
      entry_type entry;
   } qwr_type;

   // Queue status toward front and back.
   typedef struct packed {
      logic      full;
      logic      empty;
      entry_type head;
   } qstat_type;

   function automatic logic [CHAR_W-1:0] map_plain(input logic [6:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;  7'h05: ch = 7'h34;
         7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;  7'h09: ch = 7'h38;
         7'h0a: ch = 7'h39;  7'h0b: ch = 7'h30;  7'h0c: ch = 7'h2d;  7'h0d: ch = 7'h3d;
         7'h0e: ch = 7'h08;  7'h0f: ch = 7'h09;
         7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;
         7'h14: ch = 7'h74;  7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;
         7'h18: ch = 7'h6f;  7'h19: ch = 7'h70;  7'h1a: ch = 7'h5b;  7'h1b: ch = 7'h5d;
         7'h1c: ch = 7'h0a;  7'h1e: ch = 7'h61;  7'h1f: ch = 7'h73;
         7'h20: ch = 7'h64;  7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
         7'h24: ch = 7'h6a;  7'h25: ch = 7'h6b;  7'h26: ch = 7'h6c;  7'h27: ch = 7'h3b;
         7'h28: ch = 7'h27;  7'h29: ch = 7'h60;  7'h2b: ch = 7'h5c;
         7'h2c: ch = 7'h7a;  7'h2d: ch = 7'h78;  7'h2e: ch = 7'h63;  7'h2f: ch = 7'h76;
         7'h30: ch = 7'h62;  7'h31: ch = 7'h6e;  7'h32: ch = 7'h6d;  7'h33: ch = 7'h2c;
         7'h34: ch = 7'h2e;  7'h35: ch = 7'h2f;  7'h37: ch = 7'h2a;  7'h39: ch = 7'h20;
         7'h47: ch = 7'h37;  7'h48: ch = 7'h38;  7'h49: ch = 7'h39;  7'h4a: ch = 7'h2d;
         7'h4b: ch = 7'h34;  7'h4c: ch = 7'h35;  7'h4d: ch = 7'h36;  7'h4e: ch = 7'h2b;
         7'h4f: ch = 7'h31;  7'h50: ch = 7'h32;  7'h51: ch = 7'h33;  7'h52: ch = 7'h30;
         7'h53: ch = 7'h2e;
         default: ch = CH_UNMAP;
      endcase
      return ch;
   endfunction

   function automatic logic [CHAR_W-1:0] map_shifted(input logic [6:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;  7'h05: ch = 7'h24;
         7'h06: ch = 7'h25;  7'h07: ch = 7'h5e;  7'h08: ch = 7'h26;  7'h09: ch = 7'h2a;
         7'h0a: ch = 7'h28;  7'h0b: ch = 7'h29;  7'h0c: ch = 7'h5f;  7'h0d: ch = 7'h2b;
         7'h0e: ch = CH_UNMAP;
         7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;
         7'h14: ch = 7'h54;  7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;
         7'h18: ch = 7'h4f;  7'h19: ch = 7'h50;  7'h1a: ch = 7'h7b;  7'h1b: ch = 7'h7d;
         7'h1e: ch = 7'h41;  7'h1f: ch = 7'h53;
         7'h20: ch = 7'h44;  7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
         7'h24: ch = 7'h4a;  7'h25: ch = 7'h4b;  7'h26: ch = 7'h4c;  7'h27: ch = 7'h3a;
         7'h28: ch = 7'h22;  7'h29: ch = 7'h7e;  7'h2b: ch = 7'h7c;
         7'h2c: ch = 7'h5a;  7'h2d: ch = 7'h58;  7'h2e: ch = 7'h43;  7'h2f: ch = 7'h56;
         7'h30: ch = 7'h42;  7'h31: ch = 7'h4e;  7'h32: ch = 7'h4d;  7'h33: ch = 7'h3c;
         7'h34: ch = 7'h3e;  7'h35: ch = CH_UNMAP;
         default: ch = map_plain(code);
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== sv/ps2sc_front.sv =====
// Front end: accepts scancode words, tracks modifiers, builds queue entries.
// Depends on ps2sc_pkg.
`default_nettype none
module ps2sc_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [7:0]            req_scan_code,
   input  ps2sc_pkg::qstat_type  qstat,
   output ps2sc_pkg::qwr_type    qwr
);
   import ps2sc_pkg::*;

   logic       shift_held_ff, shift_held_in;
   logic       caps_held_ff,  caps_held_in;
   logic       caps_latched_ff, caps_latched_in;
   logic       accept;
   logic       is_release;
   logic [6:0] key;
   logic       is_shift_key;
   logic       emit;
   logic [CHAR_W-1:0] base_ch;
   logic       use_shift;
   entry_type  ent;

   assign req_ready    = !qstat.full;
   assign accept       = req_valid && req_ready;
   assign is_release   = req_scan_code[7];
   assign key          = req_scan_code[6:0];
   assign is_shift_key = (key == SC_SHIFT_L) || (key == SC_SHIFT_R);
   assign base_ch      = map_plain(key);

   always_comb begin
      use_shift = shift_held_ff;
      if ((base_ch >= CH_LC_A) && (base_ch <= CH_LC_Z) && (caps_held_ff || caps_latched_ff)) begin
         use_shift = !shift_held_ff;
      end
   end

   // Classify the word and fill the entry.
   always_comb begin
      emit        = 1'b0;
      ent.len_m1  = '0;
      ent.chars   = '0;
      if (req_scan_code != SC_IGNORE && !is_release && !is_shift_key && key != SC_CAPS) begin
         emit = 1'b1;
         ent.chars[0] = CH_ESC;
         ent.len_m1   = LEN_W'(2);
         case (key)
            SC_LEFT: begin
               ent.chars[1] = CH_CSI;  ent.chars[2] = CH_LEFT;
            end
            SC_RIGHT: begin
               ent.chars[1] = CH_CSI;  ent.chars[2] = CH_RIGHT;
            end
            SC_UP: begin
               ent.chars[1] = CH_CSI;  ent.chars[2] = CH_UP;
            end
            SC_DOWN: begin
               ent.chars[1] = CH_CSI;  ent.chars[2] = CH_DOWN;
            end
            SC_HOME: begin
               ent.chars[1] = CH_SS3;  ent.chars[2] = CH_HOME;
            end
            SC_END: begin
               ent.chars[1] = CH_SS3;  ent.chars[2] = CH_END;
            end
            SC_DEL: begin
               ent.chars[1] = CH_CSI;  ent.chars[2] = CH_DEL;
               ent.chars[3] = CH_TILDE;
               ent.len_m1   = LEN_W'(3);
            end
            default: begin
               ent.len_m1   = '0;
               ent.chars[0] = use_shift ? map_shifted(key) : base_ch;
            end
         endcase
      end
   end

   // Modifier tracking, applied only on accepted words.
   always_comb begin
      shift_held_in   = shift_held_ff;
      caps_held_in    = caps_held_ff;
      caps_latched_in = caps_latched_ff;
      if (accept && req_scan_code != SC_IGNORE) begin
         if (is_shift_key) begin
            shift_held_in = !is_release;
         end else if (key == SC_CAPS) begin
            caps_held_in = !is_release;
            if (is_release) begin
               caps_latched_in = !caps_latched_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff   <= 1'b0;
         caps_held_ff    <= 1'b0;
         caps_latched_ff <= 1'b0;
      end else begin
         shift_held_ff   <= shift_held_in;
         caps_held_ff    <= caps_held_in;
         caps_latched_ff <= caps_latched_in;
      end
   end

   assign qwr.push  = accept && emit;
   assign qwr.entry = ent;

endmodule
`default_nettype wire

// ===== sv/ps2sc_queue.sv =====
// Short queue of translated entries between front and back end.
// Depends on ps2sc_pkg.
`default_nettype none
module ps2sc_queue #(
   parameter int DEPTH = 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  ps2sc_pkg::qwr_type    qwr,
   input  wire                   pop,
   output ps2sc_pkg::qstat_type  qstat
);
   import ps2sc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign qstat.head  = slot_ff[rd_ptr_ff];

   assign do_push = qwr.push && !qstat.full;
   assign do_pop  = pop && !qstat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= qwr.entry;
      end
   end

endmodule
`default_nettype wire

// ===== sv/ps2sc_back.sv =====
// Back end: holds one entry and sends its characters one word per cycle while rsp_ready is high.
// Depends on ps2sc_pkg.
`default_nettype none
module ps2sc_back (
   input  wire                   clock,
   input  wire                   reset,
   input  ps2sc_pkg::qstat_type  qstat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [6:0]            rsp_ascii_char,
   output logic                  rsp_last_of_run
);
   import ps2sc_pkg::*;

   entry_type              cur_ff, cur_in;
   logic                   busy_ff, busy_in;
   logic [LEN_W-1:0]       idx_ff, idx_in;
   logic                   is_last;
   logic                   load;

   assign is_last = (idx_ff == cur_ff.len_m1);
   assign load    = !qstat.empty && (!busy_ff || (rsp_ready && is_last));
   assign pop     = load;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         cur_in  = qstat.head;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff && rsp_ready) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_valid       = busy_ff;
   assign rsp_ascii_char  = cur_ff.chars[idx_ff];
   assign rsp_last_of_run = is_last;

endmodule
`default_nettype wire

// ===== sv/ps2_scancode_to_ascii.sv =====
// Top level of the set-1 scancode to ASCII translator.
// Depends on ps2sc_pkg, ps2sc_front, ps2sc_queue, ps2sc_back and the assert header.
//
// Usage:
//   req channel: one raw set-1 scancode word per handshake (bit 7 = release).
//   rsp channel: one character word per handshake; rsp_last_of_run marks the
//   final character produced for a scancode. Arrow keys, Home, End and Delete
//   give three or four characters of an ANSI escape sequence, every other
//   pressed key one character. Releases, modifier presses and byte 0x7f give
//   no word at all; at most they update the shift and Caps Lock tracking.
// Path: the word is written into the queue, then loaded into the output register
//   once the back end is free, and from there its first character is offered.
// Throughput: the back end sends one character per cycle while rsp_ready is
//   high, and a scancode gives one to four characters. The front end accepts a
//   word every cycle while the queue (QUEUE_DEPTH entries) has room.
// Reset: clears modifier state, empties the queue and drops any word in flight.
// Stall: while rsp_ready is low the current character holds; the front keeps
//   accepting until the queue fills, then drops req_ready.
`default_nettype none
module ps2_scancode_to_ascii #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_scan_code,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [6:0]  rsp_ascii_char,
   output logic        rsp_last_of_run
);
   import ps2sc_pkg::*;

   qwr_type    qwr;
   qstat_type  qstat;
   logic       pop;

   // Classify and translate; advance modifier state on every accepted word but 0x7f.
   ps2sc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_scan_code (req_scan_code),
      .qstat         (qstat),
      .qwr           (qwr)
   );

   // Decouple translation from delivery.
   ps2sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .qwr   (qwr),
      .pop   (pop),
      .qstat (qstat)
   );

   // Send the characters of one entry, one word per cycle while rsp_ready is high.
   ps2sc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

`include "ps2_scancode_to_ascii_assert.svh"

   // Never push into a full queue.
   `PS2SC_NEVER(a_no_overflow, clock, reset, qwr.push && qstat.full)
   // Release words never produce characters.
   `PS2SC_NEVER(a_release_silent, clock, reset, qwr.push && req_scan_code[7])
   // A run continues without a gap until its last character.
   `PS2SC_ASSERT(a_run_contiguous, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
   // A multi-character run that directly follows another run opens with ESC.
   `PS2SC_ASSERT(a_esc_first, clock, reset, rsp_valid && rsp_ready && rsp_last_of_run |=> !rsp_valid || rsp_last_of_run || rsp_ascii_char == CH_ESC)

endmodule
`default_nettype wire
